// ----- sv/f2h_pkg.sv -----
// Shared constants for the single to half precision converter.
package f2h_pkg;

  localparam int F32_WIDTH = 32;
  localparam int F16_WIDTH = 16;
  localparam int F32_MAN_WIDTH = 23;
  localparam int F16_MAN_WIDTH = 10;
  localparam int F16_EXP_WIDTH = 5;
  localparam int DROP_BITS = F32_MAN_WIDTH - F16_MAN_WIDTH;

  localparam logic [7:0] F32_EXP_ALL_ONES = 8'hff;
  localparam logic [7:0] REBIAS           = 8'd112;
  localparam logic [7:0] SUB_MIN_EXP      = 8'd102;
  localparam logic [8:0] HALF_EXP_MAX     = 9'd30;
  localparam logic [F16_EXP_WIDTH-1:0] HALF_EXP_ALL_ONES = 5'h1f;
  localparam logic [F32_MAN_WIDTH:0] ROUND_ADD = 24'h002000;

endpackage

// ----- sv/f2h_convert.sv -----
// Combinational single to half precision bit pattern conversion.
module f2h_convert (
  input  logic [f2h_pkg::F32_WIDTH-1:0] float_bits,
  output logic [f2h_pkg::F16_WIDTH-1:0] half_bits
);

  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_SUB,
    CLS_NORM,
    CLS_SPECIAL
  } class_t;

  logic                                sign;
  logic [7:0]                          exp8;
  logic [f2h_pkg::F32_MAN_WIDTH-1:0]   man;
  class_t                              cls;
  logic [7:0]                          sub_diff;
  logic [3:0]                          sub_shift;
  logic [f2h_pkg::F32_MAN_WIDTH:0]     sub_man;
  logic [f2h_pkg::F32_MAN_WIDTH:0]     sub_rnd;
  logic [f2h_pkg::F32_MAN_WIDTH:0]     nrm_rnd;
  logic                                nrm_carry;
  logic [8:0]                          nrm_exp;
  logic [f2h_pkg::F16_MAN_WIDTH-1:0]   nan_top;
  logic [f2h_pkg::F16_MAN_WIDTH-1:0]   nan_man;

  assign sign = float_bits[31];
  assign exp8 = float_bits[30:23];
  assign man  = float_bits[22:0];

  always_comb begin
    if (exp8 == f2h_pkg::F32_EXP_ALL_ONES) begin
      cls = CLS_SPECIAL;
    end else if (exp8 > f2h_pkg::REBIAS) begin
      cls = CLS_NORM;
    end else if (exp8 >= f2h_pkg::SUB_MIN_EXP) begin
      cls = CLS_SUB;
    end else begin
      cls = CLS_ZERO;
    end
  end

  // shift right by one minus the rebiased exponent, 1 to 11
  assign sub_diff  = f2h_pkg::REBIAS + 8'd1 - exp8;
  assign sub_shift = sub_diff[3:0];
  assign sub_man   = {1'b1, man} >> sub_shift;
  assign sub_rnd   = sub_man + (sub_man[12] ? f2h_pkg::ROUND_ADD : '0);

  assign nrm_rnd   = {1'b0, man} + (man[12] ? f2h_pkg::ROUND_ADD : '0);
  assign nrm_carry = nrm_rnd[f2h_pkg::F32_MAN_WIDTH];
  assign nrm_exp   = {1'b0, exp8} - {1'b0, f2h_pkg::REBIAS} + {8'd0, nrm_carry};

  assign nan_top = man[22:13];
  assign nan_man = nan_top | {9'd0, (nan_top == '0) && (man != '0)};

  always_comb begin
    unique case (cls)
      CLS_ZERO: begin
        half_bits = '0;
      end
      CLS_SUB: begin
        half_bits = {sign, 4'd0, sub_rnd[23:13]};
      end
      CLS_NORM: begin
        if (nrm_exp > f2h_pkg::HALF_EXP_MAX) begin
          half_bits = {sign, f2h_pkg::HALF_EXP_ALL_ONES, 10'd0};
        end else begin
          half_bits = {sign, nrm_exp[4:0], nrm_rnd[22:13]};
        end
      end
      CLS_SPECIAL: begin
        half_bits = {sign, f2h_pkg::HALF_EXP_ALL_ONES, nan_man};
      end
      default: begin
        half_bits = '0;
      end
    endcase
  end

endmodule

// ----- sv/float32_to_float16_unit.sv -----
// Top level: input register, conversion logic and result register.
//
// Converts an IEEE single-precision bit pattern to half precision with
// half-up rounding on the dropped bits, saturation to infinity, flush of
// tiny values to plus zero and NaN payload kept nonzero. One word is taken
// every clock while in_stall is low; each word passes through the input
// register and then the result register, with the conversion logic
// between them. Both registers hold under stall and refill as soon as the
// result is taken, so a full pipeline keeps one word per cycle.
module float32_to_float16_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [f2h_pkg::F32_WIDTH-1:0] float_bits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [f2h_pkg::F16_WIDTH-1:0] half_bits
);

  logic                          s1_valid;
  logic [f2h_pkg::F32_WIDTH-1:0] s1_bits;
  logic [f2h_pkg::F16_WIDTH-1:0] half_next;
  logic                          advance;
  logic                          load;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign load     = in_valid && !in_stall;

  f2h_convert u_convert (
    .float_bits (s1_bits),
    .half_bits  (half_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (!s1_valid || advance) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_bits <= float_bits;
    end
    if (advance && s1_valid) begin
      half_bits <= half_next;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_bits))
    else $error("input register changed while blocked");

  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    load |=> s1_valid)
    else $error("accepted word lost from input register");

  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid |=> out_valid)
    else $error("converted word lost from result register");

  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !s1_valid |=> !out_valid)
    else $error("result word repeated");

endmodule
